// ===== rtl/core/ddf_pkg.sv =====
`default_nettype none
// ============================================================================
// ddf_pkg
// Shared types and constants of the decimal display formatter.
// ============================================================================
package ddf_pkg;

    // Digit positions handled by the divider, units position is 0.
    localparam int unsigned MAX_DIGITS = 10;
    localparam int unsigned POS_W      = $clog2(MAX_DIGITS + 1);

    localparam logic [POS_W-1:0] TOP_POS = POS_W'(MAX_DIGITS - 1);

    // Powers of ten, one for each digit position.
    localparam logic [31:0] POW10 [MAX_DIGITS] = '{
        32'd1, 32'd10, 32'd100, 32'd1000, 32'd10000, 32'd100000,
        32'd1000000, 32'd10000000, 32'd100000000, 32'd1000000000
    };

    // ASCII codes.
    localparam logic [6:0] CHAR_NUL   = 7'h00;
    localparam logic [6:0] CHAR_SPACE = 7'h20;
    localparam logic [6:0] CHAR_POINT = 7'h2E;
    localparam logic [6:0] CHAR_ZERO  = 7'h30;

    // Configuration register indexes.
    localparam logic [1:0] REG_DIGIT_COUNT   = 2'd0;
    localparam logic [1:0] REG_POINT_PLACES  = 2'd1;
    localparam logic [1:0] REG_LEADING_MODE  = 2'd2;
    localparam logic [1:0] REG_TRAILING_MODE = 2'd3;

    // Zero handling modes.
    localparam logic [1:0] LEAD_SHOW   = 2'd0;
    localparam logic [1:0] LEAD_BLANK  = 2'd1;
    localparam logic [1:0] TRAIL_SHOW  = 2'd0;
    localparam logic [1:0] TRAIL_BLANK = 2'd1;
    localparam logic [1:0] TRAIL_SKIP  = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV,
        S_PNT,
        S_CHR,
        S_FLUSH
    } t_state;

    // Commands from the sequencer to the digit divider.
    typedef struct packed {
        logic load;
        logic step;
        logic next_pos;
    } t_div_ctrl;

    // Status of the digit divider.
    typedef struct packed {
        logic             done;
        logic             last_pos;
        logic             rest_zero;
        logic [POS_W-1:0] pos;
        logic [3:0]       digit;
    } t_div_stat;

endpackage
`default_nettype wire

// ===== rtl/core/ddf_digit_div.sv =====
`default_nettype none
// ============================================================================
// ddf_digit_div
// Repeated-subtraction digit divider built around one 32-bit subtractor.
// ============================================================================
module ddf_digit_div (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire  [31:0]          i_number,
    input  ddf_pkg::t_div_ctrl   i_ctrl,
    output ddf_pkg::t_div_stat   o_stat
);

    logic [31:0]               r_val;
    logic [3:0]                r_dig;
    logic [ddf_pkg::POS_W-1:0] r_pos;

    logic [31:0] w_pow;
    logic [32:0] w_diff;
    logic        w_borrow;

    // The remaining value minus the power of ten of the current position.
    assign w_pow    = ddf_pkg::POW10[r_pos];
    assign w_diff   = {1'b0, r_val} - {1'b0, w_pow};
    assign w_borrow = w_diff[32];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= ddf_pkg::TOP_POS;
            r_dig <= 4'd0;
        end else if (i_ctrl.load) begin
            r_val <= i_number;
            r_dig <= 4'd0;
            r_pos <= ddf_pkg::TOP_POS;
        end else if (i_ctrl.next_pos) begin
            r_dig <= 4'd0;
            r_pos <= r_pos - 1'b1;
        end else if (i_ctrl.step && !w_borrow) begin
            r_val <= w_diff[31:0];
            r_dig <= r_dig + 4'd1;
        end
    end

    // Once done, r_dig is the digit and r_val the value of all lower digits.
    assign o_stat.done      = w_borrow;
    assign o_stat.last_pos  = (r_pos == '0);
    assign o_stat.rest_zero = (r_val == 32'd0);
    assign o_stat.pos       = r_pos;
    assign o_stat.digit     = r_dig;

endmodule
`default_nettype wire

// ===== rtl/core/decimal_display_formatter.sv =====
`default_nettype none
// ============================================================================
// decimal_display_formatter
// Formats a 32-bit unsigned value as a string of ASCII decimal characters.
// ============================================================================
// A value is taken with start while busy is low and is then converted one
// digit position at a time, from the thousand-millions position down to
// the units, by a single 32-bit subtractor that removes the current power of
// ten until the remainder falls below it. Positions at or above digit_count
// are worked through but not shown, which keeps the value modulo
// 10^digit_count. Characters leave one per strobe on o_char_valid, most
// significant first, each with its running count and a last flag; a value
// whose string is empty gives a single NUL with last set and count 0. The
// receiver cannot stall, so it must take every strobe. The time a conversion
// takes grows with the digits of the raw input, since the subtraction loop
// of the shared divider removes one power of ten per step, and with the
// number of positions shown.
// Configuration transfers are always ready and must only be made while busy
// is low.
// ============================================================================
module decimal_display_formatter (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         start,
    output logic        busy,
    input  wire  [31:0] i_number,
    input  wire         i_cfg_valid,
    output logic        o_cfg_ready,
    input  wire  [1:0]  i_cfg_index,
    input  wire  [3:0]  i_cfg_data,
    output logic        o_char_valid,
    output logic [6:0]  o_char_code,
    output logic        o_last_char,
    output logic [3:0]  o_char_count
);

    // Configuration registers.
    logic [3:0] r_digit_count;
    logic [3:0] r_point_places;
    logic [1:0] r_leading_mode;
    logic [1:0] r_trailing_mode;

    ddf_pkg::t_state n_state, r_state;

    // Per-value flags: zeros are now shown (a significant digit came, or show mode), the point is passed.
    logic r_sig;
    logic r_frac;

    // One character is held back so that the last one can be flagged.
    logic       r_pend_vld;
    logic [6:0] r_pend_chr;
    logic [3:0] r_cnt;

    logic       r_out_vld;
    logic [6:0] r_out_chr;
    logic       r_out_last;
    logic [3:0] r_out_cnt;

    ddf_pkg::t_div_ctrl w_ctrl;
    ddf_pkg::t_div_stat w_stat;

    logic       w_push;
    logic [6:0] w_push_chr;
    logic       w_set_frac;
    logic       w_set_sig;
    logic       w_end;

    logic [3:0] w_n;
    logic       w_shown;
    logic       w_point_here;
    logic       w_tail_zero;
    logic       w_tblank;
    logic       w_tskip;

    ddf_digit_div u_div (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_number (i_number),
        .i_ctrl   (w_ctrl),
        .o_stat   (w_stat)
    );

    // Digit count is clamped to the number of positions the divider has.
    assign w_n = (r_digit_count > 4'(ddf_pkg::MAX_DIGITS)) ?
                 4'(ddf_pkg::MAX_DIGITS) : r_digit_count;

    assign w_shown      = (4'(w_stat.pos) < w_n);
    assign w_tail_zero  = (w_stat.digit == 4'd0) && w_stat.rest_zero;
    assign w_tblank     = (r_trailing_mode == ddf_pkg::TRAIL_BLANK);
    assign w_tskip      = (r_trailing_mode == ddf_pkg::TRAIL_SKIP);
    assign w_point_here = (r_point_places != 4'd0) && (r_point_places <= w_n) &&
                          (4'(w_stat.pos) == r_point_places - 4'd1);

    // A fraction that ends in zeros under skip mode stops the string here.
    assign w_end = r_frac && w_tail_zero && w_tskip;

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ddf_pkg::S_IDLE: begin
                if (start) begin
                    n_state = ddf_pkg::S_DIV;
                end
            end
            ddf_pkg::S_DIV: begin
                if (w_stat.done) begin
                    if (w_shown) begin
                        n_state = ddf_pkg::S_PNT;
                    end else if (w_stat.last_pos) begin
                        n_state = ddf_pkg::S_FLUSH;
                    end
                end
            end
            ddf_pkg::S_PNT: begin
                n_state = ddf_pkg::S_CHR;
            end
            ddf_pkg::S_CHR: begin
                if (w_end || w_stat.last_pos) begin
                    n_state = ddf_pkg::S_FLUSH;
                end else begin
                    n_state = ddf_pkg::S_DIV;
                end
            end
            ddf_pkg::S_FLUSH: begin
                n_state = ddf_pkg::S_IDLE;
            end
            default: begin
                n_state = ddf_pkg::S_IDLE;
            end
        endcase
    end

    // Sequencer outputs.
    always_comb begin
        w_ctrl     = '0;
        w_push     = 1'b0;
        w_push_chr = ddf_pkg::CHAR_NUL;
        w_set_frac = 1'b0;
        w_set_sig  = 1'b0;
        case (r_state)
            ddf_pkg::S_IDLE: begin
                w_ctrl.load = start;
            end
            ddf_pkg::S_DIV: begin
                w_ctrl.step = 1'b1;
                // Hidden positions only reduce the value.
                if (w_stat.done && !w_shown && !w_stat.last_pos) begin
                    w_ctrl.next_pos = 1'b1;
                end
            end
            ddf_pkg::S_PNT: begin
                if (w_point_here) begin
                    w_set_frac = 1'b1;
                    // An all-zero fraction drops the point when blanked or skipped.
                    if (!((w_tblank || w_tskip) && w_tail_zero)) begin
                        w_push     = 1'b1;
                        w_push_chr = ddf_pkg::CHAR_POINT;
                    end
                end
            end
            ddf_pkg::S_CHR: begin
                if (r_frac && w_tail_zero && (w_tskip || w_tblank)) begin
                    if (w_tblank) begin
                        w_push     = 1'b1;
                        w_push_chr = ddf_pkg::CHAR_SPACE;
                    end
                end else if (r_sig || (w_stat.digit != 4'd0) ||
                             (4'(w_stat.pos) == r_point_places)) begin
                    w_set_sig  = 1'b1;
                    w_push     = 1'b1;
                    w_push_chr = ddf_pkg::CHAR_ZERO + {3'b000, w_stat.digit};
                end else if (r_leading_mode == ddf_pkg::LEAD_BLANK) begin
                    w_push     = 1'b1;
                    w_push_chr = ddf_pkg::CHAR_SPACE;
                end
                if (!w_end && !w_stat.last_pos) begin
                    w_ctrl.next_pos = 1'b1;
                end
            end
            ddf_pkg::S_FLUSH: begin
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= ddf_pkg::S_IDLE;
            r_digit_count   <= 4'd10;
            r_point_places  <= 4'd0;
            r_leading_mode  <= ddf_pkg::LEAD_SHOW;
            r_trailing_mode <= ddf_pkg::TRAIL_SHOW;
            r_sig           <= 1'b0;
            r_frac          <= 1'b0;
            r_pend_vld      <= 1'b0;
            r_cnt           <= 4'd0;
            r_out_vld       <= 1'b0;
        end else begin
            r_state <= n_state;

            // A character is strobed when a new one releases it or at the flush.
            r_out_vld <= (w_push && r_pend_vld) || (r_state == ddf_pkg::S_FLUSH);

            if (i_cfg_valid) begin
                case (i_cfg_index)
                    ddf_pkg::REG_DIGIT_COUNT:   r_digit_count   <= i_cfg_data;
                    ddf_pkg::REG_POINT_PLACES:  r_point_places  <= i_cfg_data;
                    ddf_pkg::REG_LEADING_MODE:  r_leading_mode  <= i_cfg_data[1:0];
                    ddf_pkg::REG_TRAILING_MODE: r_trailing_mode <= i_cfg_data[1:0];
                    default: begin
                    end
                endcase
            end

            if (w_ctrl.load) begin
                r_sig      <= (r_leading_mode == ddf_pkg::LEAD_SHOW);
                r_frac     <= 1'b0;
                r_pend_vld <= 1'b0;
                r_cnt      <= 4'd0;
            end
            if (w_set_frac) begin
                r_frac <= 1'b1;
            end
            if (w_set_sig) begin
                r_sig <= 1'b1;
            end

            // A new character releases the one held before it.
            if (w_push) begin
                if (r_pend_vld) begin
                    r_out_chr  <= r_pend_chr;
                    r_out_last <= 1'b0;
                    r_out_cnt  <= r_cnt + 4'd1;
                    r_cnt      <= r_cnt + 4'd1;
                end
                r_pend_vld <= 1'b1;
                r_pend_chr <= w_push_chr;
            end

            // The held character is the last; with none the string is empty.
            if (r_state == ddf_pkg::S_FLUSH) begin
                r_out_last <= 1'b1;
                r_pend_vld <= 1'b0;
                if (r_pend_vld) begin
                    r_out_chr <= r_pend_chr;
                    r_out_cnt <= r_cnt + 4'd1;
                end else begin
                    r_out_chr <= ddf_pkg::CHAR_NUL;
                    r_out_cnt <= 4'd0;
                end
            end
        end
    end

    assign busy         = (r_state != ddf_pkg::S_IDLE);
    assign o_cfg_ready  = 1'b1;
    assign o_char_valid = r_out_vld;
    assign o_char_code  = r_out_chr;
    assign o_last_char  = r_out_last;
    assign o_char_count = r_out_cnt;

    // The last character closes the string and nothing follows it at once.
    a_last_then_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_char_valid && o_last_char) |=> !o_char_valid)
        else $error("character transfer right after the last character");

    // A character that is not the last belongs to a conversion still running.
    a_mid_while_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_char_valid && !o_last_char) |-> busy)
        else $error("non-final character while idle");

    // A count of zero marks only the empty string.
    a_empty_is_nul: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_char_valid && (o_char_count == 4'd0)) |-> (o_last_char &&
        (o_char_code == ddf_pkg::CHAR_NUL)))
        else $error("zero count on a non-empty character");

    // An accepted value starts a conversion.
    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted value did not start a conversion");

endmodule
`default_nettype wire
